// ===== sv/adcts_pkg.sv =====
package adcts_pkg;

    // field widths
    localparam int SAMPLE_W  = 10;
    localparam int TENTHS_W  = 13;
    localparam int SEG_W     = 8;
    localparam int IND_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int DIGIT_W   = 4;

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

    // conversion: tenths = floor((c*10000 + FS) / (2*FS))
    localparam int ADC_FULL_SCALE = 1023;
    localparam int SCALE_NUM      = 10000;
    localparam int DIVISOR        = 2 * ADC_FULL_SCALE;
    localparam int MAX_TENTHS     = (ADC_FULL_SCALE * SCALE_NUM + ADC_FULL_SCALE) / DIVISOR;
    localparam int NUM_W          = $clog2(ADC_FULL_SCALE * SCALE_NUM + ADC_FULL_SCALE + 1);
    localparam int DIV_BITS       = $clog2(DIVISOR + 1);

    // reciprocal for exact division: 2^SHIFT exceeds max numerator times divisor
    localparam int    RECIP_SHIFT = NUM_W + DIV_BITS;
    localparam longint RECIP      = ((longint'(1) << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int    RECIP_W     = $clog2(RECIP + 1);
    localparam int    PROD_W      = NUM_W + RECIP_W;

    // decimal split widths
    localparam int Q1_W = $clog2(MAX_TENTHS / 10 + 1);
    localparam int Q2_W = $clog2(MAX_TENTHS / 100 + 1);

    // left digit shown from 10.0 degrees
    localparam int LEFT_MIN_TENTHS = 100;

    // segment constants
    localparam logic [SEG_W-1:0] DP_BIT = 8'h80;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

    // threshold reset values
    localparam logic [SAMPLE_W-1:0] RED_MIN_RESET   = 10'd68;
    localparam logic [SAMPLE_W-1:0] GREEN_MIN_RESET = 10'd52;
    localparam logic [SAMPLE_W-1:0] BLUE_MIN_RESET  = 10'd37;

    typedef enum logic [IND_W-1:0] {
        IND_OFF   = 2'd0,
        IND_BLUE  = 2'd1,
        IND_GREEN = 2'd2,
        IND_RED   = 2'd3
    } indicator_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red_min;
        logic [SAMPLE_W-1:0] green_min;
        logic [SAMPLE_W-1:0] blue_min;
    } thresholds_t;

    // converted temperature with its color
    typedef struct packed {
        logic [TENTHS_W-1:0] tenths;
        indicator_t          indicator;
    } conv_t;

    // partly split value
    typedef struct packed {
        logic [TENTHS_W-1:0] tenths;
        logic [Q2_W-1:0]     hundreds;
        logic [DIGIT_W-1:0]  d1;
        logic [DIGIT_W-1:0]  d0;
        logic                show_left;
        indicator_t          indicator;
    } digits_t;

    // result item, first field in the highest bits
    typedef struct packed {
        indicator_t          indicator;
        logic                left_enable;
        logic [SEG_W-1:0]    seg_right;
        logic [SEG_W-1:0]    seg_middle;
        logic [SEG_W-1:0]    seg_left;
        logic [TENTHS_W-1:0] tenths;
    } result_t;

    localparam int OUT_TDATA_W = (($bits(result_t) + 7) / 8) * 8;

    // divide by ten through a reciprocal, exact below 16384
    function automatic logic [TENTHS_W-1:0] div10(input logic [TENTHS_W-1:0] x);
        logic [TENTHS_W+16-1:0] p;
        p = {16'd0, x} * (TENTHS_W + 16)'(6554);
        return p[16 +: TENTHS_W];
    endfunction

    // remainder from the quotient
    function automatic logic [DIGIT_W-1:0] rem10(input logic [TENTHS_W-1:0] x,
                                                 input logic [TENTHS_W-1:0] q);
        logic [TENTHS_W-1:0] r;
        r = x - (q * TENTHS_W'(10));
        return r[DIGIT_W-1:0];
    endfunction

    // seven-segment font, bit0 is segment a
    function automatic logic [SEG_W-1:0] seg_font(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/adc_temperature_seven_segment.sv =====
// Temperature readout for a three-digit seven-segment display with an RGB
// color indicator.
// Input stream s_axis: one 10-bit converter sample per transfer.
// Output stream m_axis: one result per sample, in order: temperature in
// tenths of a degree, three segment bytes (middle one with decimal point),
// left digit enable and indicator color.
// Config channel cfg: index 0 red, 1 green, 2 blue lower sample bound;
// other indexes are ignored. cfg_ready is always high. Write only while
// the pipeline is empty.
// One sample is taken every cycle while the output is not stalled. The
// five register stages are scale, reciprocal multiply, two divide-by-ten
// steps, and the last digit with the segment encoding, which is the
// output register.
// Reset empties the pipeline and loads the default thresholds.
// When m_axis_tready is low the stages keep filling until every stage
// holds an item, then s_axis_tready drops; nothing is dropped or repeated.
module adc_temperature_seven_segment
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [9:0] sample
    input  logic [adcts_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [12:0] tenths, [20:13] seg_left, [28:21] seg_middle, [36:29] seg_right,
    // [37] left_enable, [39:38] indicator
    output logic [adcts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [adcts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [adcts_pkg::SAMPLE_W-1:0]      cfg_data
);

    localparam logic [adcts_pkg::CFG_IDX_W-1:0] REG_RED_MIN   = 2'd0;
    localparam logic [adcts_pkg::CFG_IDX_W-1:0] REG_GREEN_MIN = 2'd1;
    localparam logic [adcts_pkg::CFG_IDX_W-1:0] REG_BLUE_MIN  = 2'd2;

    adcts_pkg::thresholds_t thr_reg;
    adcts_pkg::thresholds_t thr_next;
    logic                   conv_valid;
    logic                   conv_ready;
    adcts_pkg::conv_t       conv_data;
    logic                   dig_valid;
    logic                   dig_ready;
    adcts_pkg::digits_t     dig_data;
    adcts_pkg::result_t     result;

    // threshold register writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_RED_MIN:   thr_next.red_min   = cfg_data;
                REG_GREEN_MIN: thr_next.green_min = cfg_data;
                REG_BLUE_MIN:  thr_next.blue_min  = cfg_data;
                default:       thr_next = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.red_min   <= adcts_pkg::RED_MIN_RESET;
            thr_reg.green_min <= adcts_pkg::GREEN_MIN_RESET;
            thr_reg.blue_min  <= adcts_pkg::BLUE_MIN_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    // conversion stages
    adcts_conv u_conv
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .sample     (s_axis_tdata[adcts_pkg::SAMPLE_W-1:0]),
        .thresholds (thr_reg),
        .out_valid  (conv_valid),
        .out_ready  (conv_ready),
        .out_data   (conv_data)
    );

    // decimal split stages
    adcts_digits u_digits
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (conv_valid),
        .in_ready  (conv_ready),
        .in_data   (conv_data),
        .out_valid (dig_valid),
        .out_ready (dig_ready),
        .out_data  (dig_data)
    );

    // segment encoding and output register
    adcts_seg u_seg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dig_valid),
        .in_ready  (dig_ready),
        .in_data   (dig_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

    assign m_axis_tdata = adcts_pkg::OUT_TDATA_W'(result);

`ifndef SYNTH
    // an empty output stage means every stage can move
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // left digit shown exactly from ten degrees up
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (result.left_enable ==
            (result.tenths >= adcts_pkg::TENTHS_W'(adcts_pkg::LEFT_MIN_TENTHS))))
        else $error("left digit enable disagrees with temperature");

    // blanked left digit has no segments lit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !result.left_enable |-> result.seg_left == adcts_pkg::SEG_BLANK)
        else $error("blanked left digit shows segments");

    // decimal point and range of the temperature
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> result.seg_middle[7] &&
            result.tenths <= adcts_pkg::TENTHS_W'(adcts_pkg::MAX_TENTHS))
        else $error("bad decimal point or temperature out of range");

    // a red threshold write lands in the register
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == REG_RED_MIN |=> thr_reg.red_min == $past(cfg_data))
        else $error("red threshold write lost");
`endif

endmodule

// ===== sv/adcts_conv.sv =====
module adcts_conv
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [adcts_pkg::SAMPLE_W-1:0]   sample,
    input  adcts_pkg::thresholds_t           thresholds,
    output logic                             out_valid,
    input  logic                             out_ready,
    output adcts_pkg::conv_t                 out_data
);

    localparam int NUM_W = adcts_pkg::NUM_W;

    logic                          v1_reg;
    logic                          v2_reg;
    logic                          en1;
    logic                          en2;
    logic [NUM_W-1:0]              num_reg;
    logic [NUM_W-1:0]              num_next;
    adcts_pkg::indicator_t         ind1_reg;
    adcts_pkg::indicator_t         ind1_next;
    adcts_pkg::conv_t              conv_reg;
    adcts_pkg::conv_t              conv_next;
    logic [NUM_W-1:0]              samp_ext;
    logic [NUM_W-1:0]              samp_clamp;
    logic [adcts_pkg::PROD_W-1:0]  prod;

    // stage enables, a stage moves when empty or its successor moves
    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // stage 1: clamp, scale, offset; color classification
    always_comb
    begin
        samp_ext   = NUM_W'(sample);
        samp_clamp = (samp_ext > NUM_W'(adcts_pkg::ADC_FULL_SCALE)) ?
                     NUM_W'(adcts_pkg::ADC_FULL_SCALE) : samp_ext;
        num_next   = NUM_W'(samp_clamp * NUM_W'(adcts_pkg::SCALE_NUM)
                            + NUM_W'(adcts_pkg::ADC_FULL_SCALE));
        if (sample >= thresholds.red_min)
        begin
            ind1_next = adcts_pkg::IND_RED;
        end
        else if (sample >= thresholds.green_min)
        begin
            ind1_next = adcts_pkg::IND_GREEN;
        end
        else if (sample >= thresholds.blue_min)
        begin
            ind1_next = adcts_pkg::IND_BLUE;
        end
        else
        begin
            ind1_next = adcts_pkg::IND_OFF;
        end
    end

    // stage 2: divide through the reciprocal
    always_comb
    begin
        prod                = adcts_pkg::PROD_W'(num_reg) *
                              adcts_pkg::PROD_W'(adcts_pkg::RECIP);
        conv_next.tenths    = prod[adcts_pkg::RECIP_SHIFT +: adcts_pkg::TENTHS_W];
        conv_next.indicator = ind1_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            num_reg  <= num_next;
            ind1_reg <= ind1_next;
        end
        if (en2)
        begin
            conv_reg <= conv_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = conv_reg;

endmodule

// ===== sv/adcts_digits.sv =====
module adcts_digits
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  adcts_pkg::conv_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output adcts_pkg::digits_t out_data
);

    localparam int TENTHS_W = adcts_pkg::TENTHS_W;

    typedef struct packed {
        logic [TENTHS_W-1:0]           tenths;
        logic [adcts_pkg::Q1_W-1:0]    tens;
        logic [adcts_pkg::DIGIT_W-1:0] d0;
        logic                          show_left;
        adcts_pkg::indicator_t         indicator;
    } split1_t;

    logic                v3_reg;
    logic                v4_reg;
    logic                en3;
    logic                en4;
    split1_t             s3_reg;
    split1_t             s3_next;
    adcts_pkg::digits_t  s4_reg;
    adcts_pkg::digits_t  s4_next;
    logic [TENTHS_W-1:0] q1;
    logic [TENTHS_W-1:0] q2;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign in_ready = en3;

    // stage 3: units-of-tenths digit
    always_comb
    begin
        q1                = adcts_pkg::div10(in_data.tenths);
        s3_next.tenths    = in_data.tenths;
        s3_next.tens      = q1[adcts_pkg::Q1_W-1:0];
        s3_next.d0        = adcts_pkg::rem10(in_data.tenths, q1);
        s3_next.show_left = (in_data.tenths >= TENTHS_W'(adcts_pkg::LEFT_MIN_TENTHS));
        s3_next.indicator = in_data.indicator;
    end

    // stage 4: tens-of-tenths digit
    always_comb
    begin
        q2                = adcts_pkg::div10(TENTHS_W'(s3_reg.tens));
        s4_next.tenths    = s3_reg.tenths;
        s4_next.hundreds  = q2[adcts_pkg::Q2_W-1:0];
        s4_next.d1        = adcts_pkg::rem10(TENTHS_W'(s3_reg.tens), q2);
        s4_next.d0        = s3_reg.d0;
        s4_next.show_left = s3_reg.show_left;
        s4_next.indicator = s3_reg.indicator;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en3)
            begin
                v3_reg <= in_valid;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_reg <= s3_next;
        end
        if (en4)
        begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = s4_reg;

endmodule

// ===== sv/adcts_seg.sv =====
module adcts_seg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  adcts_pkg::digits_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output adcts_pkg::result_t  out_data
);

    localparam int TENTHS_W = adcts_pkg::TENTHS_W;

    logic                          v5_reg;
    logic                          en5;
    adcts_pkg::result_t            res_reg;
    adcts_pkg::result_t            res_next;
    logic [TENTHS_W-1:0]           q3;
    logic [adcts_pkg::DIGIT_W-1:0] d2;

    assign en5      = !v5_reg || out_ready;
    assign in_ready = en5;

    // stage 5: left digit modulo ten, segment encoding, blanking
    always_comb
    begin
        q3                   = adcts_pkg::div10(TENTHS_W'(in_data.hundreds));
        d2                   = adcts_pkg::rem10(TENTHS_W'(in_data.hundreds), q3);
        res_next.tenths      = in_data.tenths;
        res_next.seg_left    = in_data.show_left ? adcts_pkg::seg_font(d2) :
                               adcts_pkg::SEG_BLANK;
        res_next.seg_middle  = adcts_pkg::seg_font(in_data.d1) | adcts_pkg::DP_BIT;
        res_next.seg_right   = adcts_pkg::seg_font(in_data.d0);
        res_next.left_enable = in_data.show_left;
        res_next.indicator   = in_data.indicator;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en5)
        begin
            v5_reg <= in_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = res_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

    // register indexes of the config channel
    localparam logic [adcts_pkg::CFG_IDX_W-1:0] REG_RED_MIN   = 2'd0;
    localparam logic [adcts_pkg::CFG_IDX_W-1:0] REG_GREEN_MIN = 2'd1;
    localparam logic [adcts_pkg::CFG_IDX_W-1:0] REG_BLUE_MIN  = 2'd2;
    localparam logic [adcts_pkg::CFG_IDX_W-1:0] REG_SPARE     = 2'd3;

    localparam int RUN_LIMIT     = 4_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 135;
    localparam int REPORT_MAX    = 10;

    // segment patterns for digits 0..9, bit0 is segment a
    localparam logic [adcts_pkg::SEG_W-1:0] DIGIT_GLYPH [0:9] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };
    localparam logic [adcts_pkg::SEG_W-1:0] POINT_SEG = 8'h80;

    // flow-control modes: none, sender idle, receiver stall, both light
    localparam int SEND_IDLE_PCT [0:3] = '{0, 72, 0, 12};
    localparam int RECV_STALL_PCT [0:3] = '{0, 0, 72, 12};

    typedef struct {
        logic [adcts_pkg::SAMPLE_W-1:0] sample;
        adcts_pkg::result_t             res;
    } readout_exp_t;

    // scoreboard: holds the thresholds and the readouts still to arrive
    class readout_scoreboard;
        adcts_pkg::thresholds_t thr;
        readout_exp_t           readout_q[$];
        int                     mismatches;
        int                     samples_in;
        int                     results_ok;
        int                     cfg_writes;
        int                     color_seen [4];

        function new();
            thr.red_min   = adcts_pkg::RED_MIN_RESET;
            thr.green_min = adcts_pkg::GREEN_MIN_RESET;
            thr.blue_min  = adcts_pkg::BLUE_MIN_RESET;
            mismatches    = 0;
            samples_in    = 0;
            results_ok    = 0;
            cfg_writes    = 0;
            foreach (color_seen[i]) color_seen[i] = 0;
        endfunction

        function void note_config(logic [adcts_pkg::CFG_IDX_W-1:0] idx,
                                  logic [adcts_pkg::SAMPLE_W-1:0] value);
            cfg_writes++;
            case (idx)
                REG_RED_MIN:   thr.red_min   = value;
                REG_GREEN_MIN: thr.green_min = value;
                REG_BLUE_MIN:  thr.blue_min  = value;
                default:       ;
            endcase
        endfunction

        // temperature, digits, segments and color of one sample
        function adcts_pkg::result_t predict_readout(logic [adcts_pkg::SAMPLE_W-1:0] s);
            adcts_pkg::result_t r;
            int unsigned        clamped;
            int unsigned        t;
            logic               shown;
            clamped = s;
            if (clamped > adcts_pkg::ADC_FULL_SCALE)
                clamped = adcts_pkg::ADC_FULL_SCALE;
            t = (clamped * 10000 + adcts_pkg::ADC_FULL_SCALE) /
                (2 * adcts_pkg::ADC_FULL_SCALE);
            shown = (t >= 100);
            r.tenths      = adcts_pkg::TENTHS_W'(t);
            r.seg_left    = shown ? DIGIT_GLYPH[(t / 100) % 10] : '0;
            r.seg_middle  = DIGIT_GLYPH[(t / 10) % 10] | POINT_SEG;
            r.seg_right   = DIGIT_GLYPH[t % 10];
            r.left_enable = shown;
            if (s >= thr.red_min)
                r.indicator = adcts_pkg::IND_RED;
            else if (s >= thr.green_min)
                r.indicator = adcts_pkg::IND_GREEN;
            else if (s >= thr.blue_min)
                r.indicator = adcts_pkg::IND_BLUE;
            else
                r.indicator = adcts_pkg::IND_OFF;
            return r;
        endfunction

        function void note_sample(logic [adcts_pkg::SAMPLE_W-1:0] s);
            readout_exp_t e;
            e.sample = s;
            e.res    = predict_readout(s);
            readout_q.push_back(e);
            samples_in++;
        endfunction

        function void compare_field(string name, logic [adcts_pkg::SAMPLE_W-1:0] s,
                                    int unsigned want, int unsigned got);
            if (want != got)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch sample %0d field %s: expected 0x%0h actual 0x%0h",
                             s, name, want, got);
            end
        endfunction

        function void check_result(logic [adcts_pkg::OUT_TDATA_W-1:0] data);
            adcts_pkg::result_t got;
            readout_exp_t       e;
            got = adcts_pkg::result_t'(data[$bits(adcts_pkg::result_t)-1:0]);
            if (readout_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result 0x%0h with no sample pending", data);
                return;
            end
            e = readout_q.pop_front();
            compare_field("tenths", e.sample, e.res.tenths, got.tenths);
            compare_field("seg_left", e.sample, e.res.seg_left, got.seg_left);
            compare_field("seg_middle", e.sample, e.res.seg_middle, got.seg_middle);
            compare_field("seg_right", e.sample, e.res.seg_right, got.seg_right);
            compare_field("left_enable", e.sample, e.res.left_enable, got.left_enable);
            compare_field("indicator", e.sample, e.res.indicator, got.indicator);
            color_seen[e.res.indicator]++;
            results_ok++;
        endfunction

        function int pending();
            return readout_q.size();
        endfunction

        function void close_out();
            if (readout_q.size() != 0)
            begin
                $display("%0d readouts never arrived", readout_q.size());
                mismatches += readout_q.size();
            end
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [adcts_pkg::IN_TDATA_W-1:0]    s_axis_tdata;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [adcts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [adcts_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [adcts_pkg::SAMPLE_W-1:0]      cfg_data;

    readout_scoreboard sb;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                settings_used;

    adc_temperature_seven_segment DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #RUN_LIMIT;
        $display("timeout with %0d readouts pending", sb.pending());
        $display("adc_temperature_seven_segment regression: fail");
        $finish;
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // input transfer monitor
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_sample(s_axis_tdata[adcts_pkg::SAMPLE_W-1:0]);
    end

    // output transfer monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // config transfer monitor
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            sb.note_config(cfg_index, cfg_data);
    end

    // offer one sample, with random idle cycles ahead of it
    task automatic push_sample(input logic [adcts_pkg::SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= adcts_pkg::IN_TDATA_W'($urandom_range(1023));
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= adcts_pkg::IN_TDATA_W'(s);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [adcts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [adcts_pkg::SAMPLE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // new thresholds, plus a write to the unused index that must be ignored
    task automatic load_thresholds(input logic [adcts_pkg::SAMPLE_W-1:0] red,
                                   input logic [adcts_pkg::SAMPLE_W-1:0] green,
                                   input logic [adcts_pkg::SAMPLE_W-1:0] blue);
        write_reg(REG_RED_MIN, red);
        write_reg(REG_SPARE, adcts_pkg::SAMPLE_W'($urandom_range(1023)));
        write_reg(REG_GREEN_MIN, green);
        write_reg(REG_BLUE_MIN, blue);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // wait for every readout, then let the pipeline settle
    task automatic drain_readouts();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly uniform, with weight near the thresholds and the display corners
    function automatic logic [adcts_pkg::SAMPLE_W-1:0] pick_sample();
        int r;
        int v;
        int corner [0:9] = '{0, 1, 20, 21, 204, 205, 409, 410, 1022, 1023};
        r = $urandom_range(99);
        if (r < 30)
        begin
            case ($urandom_range(2))
                0:       v = sb.thr.red_min;
                1:       v = sb.thr.green_min;
                default: v = sb.thr.blue_min;
            endcase
            v = v + $urandom_range(4) - 2;
            if (v < 0)
                v = 0;
            if (v > 1023)
                v = 1023;
        end
        else if (r < 40)
            v = corner[$urandom_range(9)];
        else
            v = $urandom_range(1023);
        return adcts_pkg::SAMPLE_W'(v);
    endfunction

    initial
    begin
        int          p;
        int          k;
        int          mode;
        int          directed [0:21];
        directed       = '{0, 1023, 341, 682, 1, 1022, 20, 21, 204, 205,
                           36, 37, 51, 52, 67, 68, 409, 410, 512, 999,
                           100, 1000};
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_RED_MIN;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settings_used  = 1;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed samples against the reset thresholds
        foreach (directed[i])
            push_sample(adcts_pkg::SAMPLE_W'(directed[i]));
        drain_readouts();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            // extremes and out-of-order settings first, then random ones
            case (p)
                0:       load_thresholds(10'd1023, 10'd1023, 10'd1023);
                1:       load_thresholds(10'd0, 10'd0, 10'd0);
                2:       load_thresholds(10'd10, 10'd500, 10'd1000);
                3:       load_thresholds(10'd1023, 10'd512, 10'd0);
                4:       load_thresholds(10'd600, 10'd600, 10'd600);
                5:       load_thresholds(adcts_pkg::RED_MIN_RESET,
                                         adcts_pkg::GREEN_MIN_RESET,
                                         adcts_pkg::BLUE_MIN_RESET);
                default: load_thresholds(adcts_pkg::SAMPLE_W'($urandom_range(1023)),
                                         adcts_pkg::SAMPLE_W'($urandom_range(1023)),
                                         adcts_pkg::SAMPLE_W'($urandom_range(1023)));
            endcase
            mode = p % 4;
            send_idle_pct  = SEND_IDLE_PCT[mode];
            recv_stall_pct <= RECV_STALL_PCT[mode];
            for (k = 0; k < PHASE_ITEMS; k++)
                push_sample(pick_sample());
            drain_readouts();
        end

        sb.close_out();
        $display("checked %0d readouts from %0d samples over %0d threshold settings",
                 sb.results_ok, sb.samples_in, settings_used);
        $display("config writes %0d, colors off/blue/green/red %0d/%0d/%0d/%0d",
                 sb.cfg_writes, sb.color_seen[0], sb.color_seen[1], sb.color_seen[2],
                 sb.color_seen[3]);
        if (sb.mismatches == 0)
            $display("adc_temperature_seven_segment regression: pass");
        else
            $display("adc_temperature_seven_segment regression: fail");
        $finish;
    end

endmodule
